### hw/rtl/scc_pkg.sv
// Shared constants, types and register codes of the stereo correlation cost block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package scc_pkg;

    // Item field widths
    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 6;
    localparam int COL_W    = 10;
    localparam int DISP_W   = 5;

    // Configuration register widths
    localparam int CC_W = 7;
    localparam int DC_W = 6;

    // Geometry of the disparity search and the right-sample ring
    localparam int DISP_SLOTS   = 32;
    localparam int MAX_CHANNELS = 64;
    localparam int ROW_W        = $clog2(DISP_SLOTS);
    localparam int ADDR_W       = ROW_W + CH_W;
    localparam int STORE_DEPTH  = DISP_SLOTS * MAX_CHANNELS;

    // Arithmetic widths
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int SUM_W  = 38;
    localparam int COST_W = 32;
    localparam int REM_W  = CC_W - 1;
    localparam int STEP_W = $clog2(SUM_W);

    // Saturation bounds
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic {
        REG_CHANNEL_COUNT   = 1'b0,
        REG_DISPARITY_COUNT = 1'b1
    } reg_index_t;

    // Controls broadcast from the sequencer to every cell
    typedef struct packed {
        logic shift;      // advance the right-sample chain
        logic mul;        // form left times tap
        logic acc;        // add product into the running sum
        logic div_load;   // start division, clear the sum
        logic div_step;   // one restoring division step
        logic finish;     // load the cost into the output chain
        logic out_shift;  // advance the cost chain toward the output
    } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/scc_stream_if.sv
// Valid/ready stream interfaces for the sample input and cost output channels.
// Depends on scc_pkg for the field widths.
`default_nettype none

interface scc_in_if
    import scc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [CH_W-1:0]            channel_index;
    logic [COL_W-1:0]           column;

    modport source (
        output valid, left_sample, right_sample, channel_index, column,
        input  ready
    );

    modport sink (
        input  valid, left_sample, right_sample, channel_index, column,
        output ready
    );
endinterface

interface scc_out_if
    import scc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [COST_W-1:0] cost;
    logic [DISP_W-1:0]        disparity;
    logic [COL_W-1:0]         out_column;
    logic                     last_of_pixel;

    modport source (
        output valid, cost, disparity, out_column, last_of_pixel,
        input  ready
    );

    modport sink (
        input  valid, cost, disparity, out_column, last_of_pixel,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/stereo_correlation_cost.sv
// Stereo correlation cost top level: config registers, sequencer, store, cell chain.
// Depends on scc_pkg, scc_stream_if, scc_store and scc_cell.
//
// Each accepted item carries one channel of one pixel. Items are taken one at a
// time: an item with a valid channel occupies the block while each disparity
// gets its own read through the one read port of the right-sample ring and those
// reads are shifted one per cycle into the cell chain, before all cells multiply
// and accumulate together. The last channel of a pixel adds a division start,
// 38 restoring steps run in all cells at once and a cost load, plus any wait for
// the previous pixel's costs to drain. Costs leave one per cycle whenever the
// output is ready, in rising disparity order from the head of the cell chain,
// while the next pixel's items are already being taken. Items whose
// channel is not below the channel count are taken and dropped. The ring holds
// the right samples of the last 32 columns and needs no clearing after reset;
// columns must arrive without gaps inside a row. Write the channel_count
// (byte address 0) and disparity_count (byte address 4) registers only while idle.
`default_nettype none

module stereo_correlation_cost
    import scc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    scc_in_if.sink             samples,
    scc_out_if.source          costs
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_LOAD  = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_ACC   = 8'b0001_0000,
        ST_DLOAD = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    // Configuration registers
    logic [CC_W-1:0] cc_reg;
    logic [DC_W-1:0] dc_reg;
    logic            cfg_write;
    reg_index_t      cfg_sel;
    logic [CC_W-1:0] nch_eff;
    logic [DC_W-1:0] nd_eff;

    // Sequencer
    state_t               state_reg;
    state_t               state_next;
    logic [DISP_W-1:0]    rd_d_reg;
    logic [DISP_W-1:0]    rd_d_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic                 rvalid_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic [CH_W-1:0]      ch_reg;
    logic [COL_W-1:0]     col_reg;
    logic                 last_reg;
    logic                 in_fire;
    logic                 keep;
    logic                 is_last;

    // Emitter
    logic              emit_busy_reg;
    logic              emit_busy_next;
    logic [DISP_W-1:0] emit_d_reg;
    logic [DISP_W-1:0] emit_d_next;
    logic [DISP_W-1:0] emit_last_reg;
    logic [COL_W-1:0]  emit_col_reg;
    logic              out_fire;
    logic              load_costs;

    // Store and chain
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ROW_W-1:0]           rd_row;
    logic signed [SAMPLE_W-1:0] store_rdata;
    cell_ctrl_t                 ctrl;
    logic [DISP_SLOTS-1:0]      active;
    logic signed [SAMPLE_W-1:0] tap_w  [DISP_SLOTS];
    logic signed [COST_W-1:0]   cost_w [DISP_SLOTS];

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = reg_index_t'(paddr[PADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= CC_W'(1);
            dc_reg <= DC_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_CHANNEL_COUNT:   cc_reg <= pwdata[CC_W-1:0];
                REG_DISPARITY_COUNT: dc_reg <= pwdata[DC_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_CHANNEL_COUNT:   prdata = PDATA_W'(cc_reg);
            REG_DISPARITY_COUNT: prdata = PDATA_W'(dc_reg);
        endcase
    end

    // Clamp counts: zero acts as one, large values saturate
    always_comb
    begin
        priority if (cc_reg == '0)
        begin
            nch_eff = CC_W'(1);
        end
        else if (cc_reg > CC_W'(MAX_CHANNELS))
        begin
            nch_eff = CC_W'(MAX_CHANNELS);
        end
        else
        begin
            nch_eff = cc_reg;
        end
        priority if (dc_reg == '0)
        begin
            nd_eff = DC_W'(1);
        end
        else if (dc_reg > DC_W'(DISP_SLOTS))
        begin
            nd_eff = DC_W'(DISP_SLOTS);
        end
        else
        begin
            nd_eff = dc_reg;
        end
    end

    // ---------------------------------------------------------------
    // Input item
    // ---------------------------------------------------------------
    assign samples.ready = (state_reg == ST_IDLE);
    assign in_fire       = samples.valid && samples.ready;
    assign keep          = CC_W'(samples.channel_index) < nch_eff;
    assign is_last       = CC_W'(samples.channel_index) == (nch_eff - 1'b1);

    // Hold the item while its disparities are worked through
    always_ff @(posedge clk)
    begin
        if (in_fire && keep)
        begin
            left_reg <= samples.left_sample;
            ch_reg   <= samples.channel_index;
            col_reg  <= samples.column;
            last_reg <= is_last;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        rd_d_next  = rd_d_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && keep)
                begin
                    state_next = ST_READ;
                    rd_d_next  = DISP_W'(nd_eff - 1'b1);
                end
            end
            ST_READ:
            begin
                if (rd_d_reg == '0)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    rd_d_next = rd_d_reg - 1'b1;
                end
            end
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = last_reg ? ST_DLOAD : ST_IDLE;
            ST_DLOAD:
            begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!emit_busy_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_d_reg   <= '0;
            step_reg   <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_d_reg   <= rd_d_next;
            step_reg   <= step_next;
            rvalid_reg <= (state_reg == ST_READ);
        end
    end

    // ---------------------------------------------------------------
    // Right-sample ring: write each kept item, read farthest disparity first
    // ---------------------------------------------------------------
    assign wr_addr = {samples.column[ROW_W-1:0], samples.channel_index};
    assign rd_row  = col_reg[ROW_W-1:0] - rd_d_reg[ROW_W-1:0];
    assign rd_addr = {rd_row, ch_reg};

    scc_store u_store (
        .clk     (clk),
        .wr_en   (in_fire && keep),
        .wr_addr (wr_addr),
        .wr_data (samples.right_sample),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (rd_addr),
        .rd_data (store_rdata)
    );

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    assign load_costs     = (state_reg == ST_FIN) && !emit_busy_reg;
    assign ctrl.shift     = rvalid_reg;
    assign ctrl.mul       = (state_reg == ST_MUL);
    assign ctrl.acc       = (state_reg == ST_ACC);
    assign ctrl.div_load  = (state_reg == ST_DLOAD);
    assign ctrl.div_step  = (state_reg == ST_DIV);
    assign ctrl.finish    = load_costs;
    assign ctrl.out_shift = out_fire;

    for (genvar g = 0; g < DISP_SLOTS; g++)
    begin : g_cell
        logic signed [SAMPLE_W-1:0] tap_in_g;
        logic signed [COST_W-1:0]   cost_in_g;

        // Disparity is live when enabled and the column reaches back far enough
        assign active[g] = (DC_W'(g) < nd_eff) && (col_reg >= COL_W'(g));

        if (g == 0)
        begin : g_head
            assign tap_in_g = store_rdata;
        end
        else
        begin : g_body
            assign tap_in_g = tap_w[g-1];
        end

        if (g == DISP_SLOTS - 1)
        begin : g_tail
            assign cost_in_g = '0;
        end
        else
        begin : g_inner
            assign cost_in_g = cost_w[g+1];
        end

        scc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .active   (active[g]),
            .left     (left_reg),
            .nch      (nch_eff),
            .tap_in   (tap_in_g),
            .tap_out  (tap_w[g]),
            .cost_in  (cost_in_g),
            .cost_out (cost_w[g])
        );
    end

    // ---------------------------------------------------------------
    // Emitter: one cost per accepted output item, lowest disparity first
    // ---------------------------------------------------------------
    assign out_fire = costs.valid && costs.ready;

    always_comb
    begin
        emit_busy_next = emit_busy_reg;
        emit_d_next    = emit_d_reg;
        priority if (load_costs)
        begin
            emit_busy_next = 1'b1;
            emit_d_next    = '0;
        end
        else if (out_fire)
        begin
            if (emit_d_reg == emit_last_reg)
            begin
                emit_busy_next = 1'b0;
            end
            else
            begin
                emit_d_next = emit_d_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_busy_reg <= 1'b0;
            emit_d_reg    <= '0;
        end
        else
        begin
            emit_busy_reg <= emit_busy_next;
            emit_d_reg    <= emit_d_next;
        end
    end

    // Latch the pixel's column and disparity span with its costs
    always_ff @(posedge clk)
    begin
        if (load_costs)
        begin
            emit_last_reg <= DISP_W'(nd_eff - 1'b1);
            emit_col_reg  <= col_reg;
        end
    end

    assign costs.valid         = emit_busy_reg;
    assign costs.cost          = cost_w[0];
    assign costs.disparity     = emit_d_reg;
    assign costs.out_column    = emit_col_reg;
    assign costs.last_of_pixel = (emit_d_reg == emit_last_reg);

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_emit_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        emit_busy_reg |-> (emit_d_reg <= emit_last_reg))
        else $error("emitted disparity beyond the pixel's span");

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && keep) |=> ((state_reg == ST_READ) && !samples.ready))
        else $error("kept item did not start the store reads");

    a_load_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        load_costs |=> (emit_busy_reg && (emit_d_reg == '0)))
        else $error("cost load did not start emission at disparity zero");

    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && costs.last_of_pixel) |=> !emit_busy_reg)
        else $error("emitter still busy after the pixel's last cost");

endmodule

`default_nettype wire

### hw/rtl/scc_store.sv
// Ring store of recent right samples, one row per column modulo DISP_SLOTS.
// One write port, one read port with registered read data. Depends on scc_pkg.
`default_nettype none

module scc_store
    import scc_pkg::*;
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    // Write the new sample, register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/scc_cell.sv
// One disparity cell: right-sample tap, product, saturating sum, bit-serial
// divider and one stage of the cost output chain. Depends on scc_pkg.
`default_nettype none

module scc_cell
    import scc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctrl_t                 ctrl,
    input  logic                       active,
    input  logic signed [SAMPLE_W-1:0] left,
    input  logic [CC_W-1:0]            nch,
    input  logic signed [SAMPLE_W-1:0] tap_in,
    output logic signed [SAMPLE_W-1:0] tap_out,
    input  logic signed [COST_W-1:0]   cost_in,
    output logic signed [COST_W-1:0]   cost_out
);

    logic signed [SAMPLE_W-1:0] tap_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]           mag_reg;
    logic [REM_W-1:0]           rem_reg;
    logic                       neg_reg;
    logic signed [COST_W-1:0]   cost_reg;

    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;
    logic [SUM_W-1:0]           sum_u;
    logic [SUM_W-1:0]           sum_mag;
    logic [CC_W-1:0]            trial;
    logic                       trial_ge;
    logic [COST_W-1:0]          quot_low;
    logic                       pos_over;
    logic                       neg_over;
    logic signed [COST_W-1:0]   cost_fin;

    // Add product with one guard bit, clamp to the sum range
    assign sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(prod_reg);
    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // Clear on division start, accumulate where this disparity is live
    always_comb
    begin
        sum_next = sum_reg;
        priority if (ctrl.div_load)
        begin
            sum_next = '0;
        end
        else if (ctrl.acc && active)
        begin
            sum_next = sum_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // Magnitude of the sum; division runs on magnitudes so it truncates toward zero
    assign sum_u   = sum_reg;
    assign sum_mag = sum_reg[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;

    // Restoring step: one quotient bit per cycle
    assign trial    = {rem_reg, mag_reg[SUM_W-1]};
    assign trial_ge = (trial >= nch);

    // Clamp quotient to the cost range, zero where the column is below the disparity
    assign quot_low = mag_reg[COST_W-1:0];
    assign pos_over = |mag_reg[SUM_W-1:COST_W-1];
    assign neg_over = (|mag_reg[SUM_W-1:COST_W]) || (mag_reg[COST_W-1] && (|mag_reg[COST_W-2:0]));
    always_comb
    begin
        if (!active)
        begin
            cost_fin = '0;
        end
        else if (neg_reg)
        begin
            cost_fin = neg_over ? COST_MIN : $signed(~quot_low + 1'b1);
        end
        else
        begin
            cost_fin = pos_over ? COST_MAX : $signed(quot_low);
        end
    end

    // Tap, product, divider and cost stage
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            tap_reg <= tap_in;
        end
        if (ctrl.mul)
        begin
            prod_reg <= PROD_W'(left) * PROD_W'(tap_reg);
        end
        if (ctrl.div_load)
        begin
            mag_reg <= sum_mag;
            neg_reg <= sum_reg[SUM_W-1];
            rem_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            mag_reg <= {mag_reg[SUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? REM_W'(trial - nch) : trial[REM_W-1:0];
        end
        if (ctrl.finish)
        begin
            cost_reg <= cost_fin;
        end
        else if (ctrl.out_shift)
        begin
            cost_reg <= cost_in;
        end
    end

    assign tap_out  = tap_reg;
    assign cost_out = cost_reg;

endmodule

`default_nettype wire

### tb/correlation_cost_checker.sv
`timescale 1ns / 100ps
// Checker for the stereo correlation cost block: tracks register writes and accepted
// samples, predicts the per-disparity costs and compares each result item in order.
// Depends on scc_pkg and the stream interfaces in scc_stream_if.

module correlation_cost_checker
    import scc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    scc_in_if                  samples,
    scc_out_if                 costs,
    output int                 mismatch_count,
    output int                 pending_costs
);

    typedef struct {
        logic signed [COST_W-1:0] cost;
        logic [DISP_W-1:0]        disparity;
        logic [COL_W-1:0]         column;
        logic                     last;
    } cost_result_t;

    cost_result_t               expected_costs[$];
    logic signed [SAMPLE_W-1:0] right_ring[DISP_SLOTS][MAX_CHANNELS];
    longint                     disparity_sum[DISP_SLOTS];
    logic [CC_W-1:0]            channel_cfg;
    logic [DC_W-1:0]            disparity_cfg;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Accumulate one sample into every active disparity sum; emit costs on the last channel
    task automatic predict_costs(input logic signed [SAMPLE_W-1:0] left, right,
                                 input logic [CH_W-1:0] ch, input logic [COL_W-1:0] col_in);
        int           nch;
        int           nd;
        int           col;
        int           d;
        longint       acc;
        cost_result_t result;

        nch = (channel_cfg == 0) ? 1 :
              (channel_cfg > MAX_CHANNELS) ? MAX_CHANNELS : int'(channel_cfg);
        nd  = (disparity_cfg == 0) ? 1 :
              (disparity_cfg > DISP_SLOTS) ? DISP_SLOTS : int'(disparity_cfg);
        col = int'(col_in);

        // drop channels beyond the configured count
        if (int'(ch) >= nch)
            return;

        right_ring[col % DISP_SLOTS][ch] = right;
        for (d = 0; d < nd; d++)
        begin
            if (col >= d)
            begin
                acc = disparity_sum[d]
                    + longint'(left) * longint'(right_ring[(col - d) % DISP_SLOTS][ch]);
                if (acc > longint'(SUM_MAX))
                    acc = longint'(SUM_MAX);
                if (acc < longint'(SUM_MIN))
                    acc = longint'(SUM_MIN);
                disparity_sum[d] = acc;
            end
        end

        if (int'(ch) != nch - 1)
            return;

        // mean over channels, truncated toward zero, zero where the shift leaves the row
        for (d = 0; d < nd; d++)
        begin
            acc = 0;
            if (col >= d)
            begin
                acc = disparity_sum[d] / longint'(nch);
                if (acc > longint'(COST_MAX))
                    acc = longint'(COST_MAX);
                if (acc < longint'(COST_MIN))
                    acc = longint'(COST_MIN);
            end
            result.cost      = acc[COST_W-1:0];
            result.disparity = DISP_W'(d);
            result.column    = col_in;
            result.last      = (d == nd - 1);
            expected_costs.push_back(result);
        end
        foreach (disparity_sum[i])
            disparity_sum[i] = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cost_result_t want;

        if (!rst_n)
        begin
            expected_costs.delete();
            foreach (disparity_sum[i])
                disparity_sum[i] = 0;
            foreach (right_ring[i, j])
                right_ring[i][j] = '0;
            channel_cfg    = 1;
            disparity_cfg  = 1;
            mismatch_count = 0;
            pending_costs <= 0;
        end
        else
        begin
            // compare a delivered cost item with the oldest prediction
            if (costs.valid && costs.ready)
            begin
                if (expected_costs.size() == 0)
                    report_mismatch($sformatf("unexpected cost %0d, column %0d disparity %0d",
                                              costs.cost, costs.out_column, costs.disparity));
                else
                begin
                    want = expected_costs.pop_front();
                    if (costs.cost !== want.cost)
                        report_mismatch($sformatf("column %0d disparity %0d: cost %0d, want %0d",
                                                  want.column, want.disparity,
                                                  costs.cost, want.cost));
                    if (costs.disparity !== want.disparity)
                        report_mismatch($sformatf("column %0d: disparity %0d, want %0d",
                                                  want.column, costs.disparity, want.disparity));
                    if (costs.out_column !== want.column)
                        report_mismatch($sformatf("disparity %0d: column %0d, want %0d",
                                                  want.disparity, costs.out_column, want.column));
                    if (costs.last_of_pixel !== want.last)
                        report_mismatch($sformatf("column %0d disparity %0d: last %0b, want %0b",
                                                  want.column, want.disparity,
                                                  costs.last_of_pixel, want.last));
                end
            end

            // mirror register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == REG_CHANNEL_COUNT)
                    channel_cfg = pwdata[CC_W-1:0];
                else if (paddr[PADDR_W-1:2] == REG_DISPARITY_COUNT)
                    disparity_cfg = pwdata[DC_W-1:0];
            end

            if (samples.valid && samples.ready)
                predict_costs(samples.left_sample, samples.right_sample,
                              samples.channel_index, samples.column);

            pending_costs <= expected_costs.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for stereo_correlation_cost: clock, reset, register writes, sample
// stimulus and result back-pressure. Depends on scc_pkg, scc_stream_if, the block
// and correlation_cost_checker, which does all prediction and comparison.

module tb;
    import scc_pkg::*;

    localparam int CYCLE_LIMIT         = 1_000_000;
    localparam int DRAIN_CYCLES        = 100;
    localparam int BACKPRESSURE_CYCLES = 600;
    localparam int LAST_COLUMN         = (1 << COL_W) - 1;
    localparam int LAST_CHANNEL        = (1 << CH_W) - 1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatch_count;
    int pending_costs;
    int cycle_count = 0;
    int active_ch   = 1;
    int active_disp = 1;
    int hold_request = 0;
    int in_run  = 0;
    int out_run = 0;
    bit in_calm;
    bit out_calm;

    scc_in_if  samples();
    scc_out_if costs();

    stereo_correlation_cost u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples),
        .costs   (costs)
    );

    correlation_cost_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .samples        (samples),
        .costs          (costs),
        .mismatch_count (mismatch_count),
        .pending_costs  (pending_costs)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("stereo_correlation_cost test failed");
            $finish;
        end
    end

    // Wait before an item: busy stretches draw a random wait, calm stretches none
    function automatic int draw_wait(inout int run_left, inout bit calm);
        if (run_left == 0)
        begin
            run_left = $urandom_range(1, 24);
            calm     = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return calm ? 0 : int'($urandom_range(0, 18));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        unique case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic int effective_count(input int raw, input int ceiling);
        return (raw == 0) ? 1 : (raw > ceiling) ? ceiling : raw;
    endfunction

    task automatic write_register(input reg_index_t index, input logic [PDATA_W-1:0] value);
        // setup, then access until pready, then idle
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_CHANNEL_COUNT)
            active_ch = effective_count(int'(value[CC_W-1:0]), MAX_CHANNELS);
        else
            active_disp = effective_count(int'(value[DC_W-1:0]), DISP_SLOTS);
        @(posedge clk);
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] left, right,
                               input int ch, input int col);
        int gap;

        gap = draw_wait(in_run, in_calm);
        if (gap > 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples.valid         <= 1'b1;
        samples.left_sample   <= left;
        samples.right_sample  <= right;
        samples.channel_index <= CH_W'(ch);
        samples.column        <= COL_W'(col);
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every predicted cost, then let the block go idle
    task automatic settle();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (pending_costs != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Send pixels of a row; a messy row mixes in dropped channels and abandoned pixels
    task automatic send_row(input int first_col, input int pixels, input bit consecutive,
                            input bit messy);
        int p;
        int c;
        int col;
        int partial;

        for (p = 0; p < pixels; p++)
        begin
            col = consecutive ? first_col + p : int'($urandom_range(0, LAST_COLUMN));
            if (messy && active_ch < MAX_CHANNELS && $urandom_range(0, 4) == 0)
                push_sample(pick_sample(), pick_sample(),
                            $urandom_range(active_ch, LAST_CHANNEL),
                            $urandom_range(0, LAST_COLUMN));
            // abandon a pixel part way, then restart it at the same column
            if (messy && active_ch > 1 && $urandom_range(0, 4) == 0)
            begin
                partial = $urandom_range(0, active_ch - 2);
                for (c = 0; c <= partial; c++)
                    push_sample(pick_sample(), pick_sample(), c, col);
            end
            for (c = 0; c < active_ch; c++)
                push_sample(pick_sample(), pick_sample(), c, col);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;

        costs.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            stall = draw_wait(out_run, out_calm);
            if (hold_request > 0)
            begin
                stall        = stall + hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                costs.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            costs.ready <= 1'b1;
            @(posedge clk);
            while (!costs.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        samples.valid         = 1'b0;
        samples.left_sample   = '0;
        samples.right_sample  = '0;
        samples.channel_index = '0;
        samples.column        = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one channel, one disparity; extreme samples and columns
        push_sample(SAMPLE_MIN, SAMPLE_MIN, 0, 0);
        push_sample(SAMPLE_MAX, SAMPLE_MAX, 0, LAST_COLUMN);
        push_sample(SAMPLE_MIN, SAMPLE_MAX, 0, 512);
        push_sample(SAMPLE_MAX, SAMPLE_MIN, LAST_CHANNEL, 700);
        push_sample('0, '0, 0, 341);
        settle();

        // Two channels, three disparities: zero costs at the row start, then
        // repeated first channels drive the cost past both 32-bit limits
        write_register(REG_CHANNEL_COUNT, 2);
        write_register(REG_DISPARITY_COUNT, 3);
        push_sample(pick_sample(), pick_sample(), 0, 0);
        push_sample(pick_sample(), pick_sample(), 1, 0);
        repeat (5) push_sample(SAMPLE_MIN, SAMPLE_MIN, 0, 1);
        push_sample(SAMPLE_MIN, SAMPLE_MIN, 1, 1);
        repeat (5) push_sample(SAMPLE_MIN, SAMPLE_MAX, 0, 2);
        push_sample(SAMPLE_MIN, SAMPLE_MAX, 1, 2);
        settle();

        // Zero channel count reads as one; disparity count saturates at the maximum
        write_register(REG_CHANNEL_COUNT, 0);
        write_register(REG_DISPARITY_COUNT, 63);
        send_row(0, 33, 1'b1, 1'b1);
        settle();

        // Channel count saturates; zero disparity count reads as one
        write_register(REG_CHANNEL_COUNT, 127);
        write_register(REG_DISPARITY_COUNT, 0);
        send_row(0, 1, 1'b0, 1'b0);
        settle();

        // Upper data bits are ignored by both registers
        write_register(REG_CHANNEL_COUNT, 32'hFFFF_FF83);
        write_register(REG_DISPARITY_COUNT, 32'hFFFF_FFC5);
        send_row(0, 3, 1'b1, 1'b1);
        settle();

        // Hold the result side off long enough to back the block up
        write_register(REG_CHANNEL_COUNT, 2);
        write_register(REG_DISPARITY_COUNT, 32);
        hold_request = BACKPRESSURE_CYCLES;
        send_row(0, 5, 1'b1, 1'b1);
        settle();

        if (mismatch_count == 0)
            $display("stereo_correlation_cost test passed");
        else
            $display("stereo_correlation_cost test failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/scc_pkg.sv
hw/rtl/scc_stream_if.sv
hw/rtl/scc_store.sv
hw/rtl/scc_cell.sv
hw/rtl/stereo_correlation_cost.sv
tb/correlation_cost_checker.sv
tb/tb.sv
